[sv/fsnc_pkg.sv]
// Package: shared constants, types and the byte sanitiser of the short name converter.
package fsnc_pkg;

    localparam int BASE_LEN    = 8;
    localparam int ENTRY_LEN   = 11;
    localparam int EXT_LEN     = ENTRY_LEN - BASE_LEN;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(ENTRY_LEN);
    localparam int BCNT_W      = $clog2(BASE_LEN + 1);
    localparam int ECNT_W      = $clog2(EXT_LEN + 1);

    localparam logic [7:0] NUL_CHAR = 8'h00;
    localparam logic [7:0] PAD_CHAR = 8'h20;
    localparam logic [7:0] SUB_CHAR = 8'h5F;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef logic [ENTRY_LEN-1:0][7:0] entry_t;

    typedef enum logic
    {
        PHASE_BASE,
        PHASE_EXT
    } phase_t;

    // Pass A-Z, 0-9, !#$%&'()@`_-{}~ and space; fold a-z; all else to '_'.
    function automatic logic [7:0] clean_byte(input logic [7:0] c);
        logic pass;
        logic lower;
        begin
            pass = (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h30 && c <= 8'h39) ||
                   (c >= 8'h23 && c <= 8'h29) ||
                   (c == 8'h21) || (c == 8'h40) || (c == 8'h60) ||
                   (c == 8'h5F) || (c == 8'h2D) || (c == 8'h7B) ||
                   (c == 8'h7D) || (c == 8'h7E) || (c == PAD_CHAR);
            lower = (c > 8'h60) && (c < 8'h7B);
            if (pass)
            begin
                clean_byte = c;
            end
            else if (lower)
            begin
                clean_byte = c - CASE_OFS;
            end
            else
            begin
                clean_byte = SUB_CHAR;
            end
        end
    endfunction

endpackage

[sv/fsnc_if.sv]
// Interfaces: name byte input channel and entry byte output channel.
interface fsnc_in_if
    import fsnc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;

    modport source (output valid, output name_byte, input ready);
    modport sink (input valid, input name_byte, output ready);
endinterface

interface fsnc_out_if
    import fsnc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

[sv/fsnc_front.sv]
// Front end: takes name bytes, sanitises them and assembles the 11-byte entry.
module fsnc_front
    import fsnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_entry
);

    entry_t              entry_buffer_reg, entry_buffer_next;
    phase_t              phase_reg, phase_next;
    logic [BCNT_W-1:0]   base_count_reg, base_count_next;
    logic [ECNT_W-1:0]   ext_count_reg, ext_count_next;
    logic                accept;
    logic [7:0]          cleaned;
    logic [IDX_W-1:0]    ext_idx;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign cleaned    = clean_byte(in_byte);
    assign ext_idx    = IDX_W'(BASE_LEN) + IDX_W'(ext_count_reg);
    assign push_entry = entry_buffer_reg;

    always_comb
    begin
        entry_buffer_next = entry_buffer_reg;
        phase_next        = phase_reg;
        base_count_next   = base_count_reg;
        ext_count_next    = ext_count_reg;
        push              = 1'b0;
        if (accept)
        begin
            if (in_byte == NUL_CHAR)
            begin
                push = 1'b1;
                for (int k = 0; k < ENTRY_LEN; k++)
                begin
                    entry_buffer_next[k] = PAD_CHAR;
                end
                phase_next      = PHASE_BASE;
                base_count_next = '0;
                ext_count_next  = '0;
            end
            else if (phase_reg == PHASE_BASE)
            begin
                if (in_byte == DOT_CHAR)
                begin
                    phase_next = PHASE_EXT;
                end
                else if (in_byte == PAD_CHAR && base_count_reg == '0)
                begin
                    // leading space dropped
                end
                else if (base_count_reg < BCNT_W'(BASE_LEN))
                begin
                    entry_buffer_next[IDX_W'(base_count_reg)] = cleaned;
                    base_count_next = base_count_reg + 1'b1;
                end
            end
            else
            begin
                if (in_byte != PAD_CHAR && ext_count_reg < ECNT_W'(EXT_LEN))
                begin
                    entry_buffer_next[ext_idx] = cleaned;
                    ext_count_next = ext_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRY_LEN; k++)
            begin
                entry_buffer_reg[k] <= PAD_CHAR;
            end
            phase_reg      <= PHASE_BASE;
            base_count_reg <= '0;
            ext_count_reg  <= '0;
        end
        else
        begin
            entry_buffer_reg <= entry_buffer_next;
            phase_reg        <= phase_next;
            base_count_reg   <= base_count_next;
            ext_count_reg    <= ext_count_next;
        end
    end

endmodule

[sv/fsnc_queue.sv]
// Short FIFO of finished entries between front and back end.
module fsnc_queue
    import fsnc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head_entry
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/fsnc_back.sv]
// Back end: serialises queued entries onto the output channel, one byte per item.
module fsnc_back
    import fsnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    entry_t             entry_reg, entry_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               busy_reg, busy_next;
    logic               last;

    assign last      = (idx_reg == IDX_W'(ENTRY_LEN - 1));
    assign out_valid = busy_reg;
    assign out_byte  = entry_reg[idx_reg];
    assign out_last  = last;

    always_comb
    begin
        entry_next = entry_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        pop        = 1'b0;
        if (!busy_reg || (out_ready && last))
        begin
            // free, or last byte leaving: take the next entry if there is one
            pop        = !q_empty;
            busy_next  = !q_empty;
            entry_next = head_entry;
            idx_next   = '0;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[sv/fat_short_name_converter.sv]
// Top level of the FAT 8.3 short name converter.
//
// name_in (sink): one file name byte per item; a zero byte ends the name.
// entry_out (source): the 11-byte 8.3 entry, base then extension, one byte
//   per item, out_last high on the eleventh byte.
// Name bytes are taken at one per cycle unless the entry queue is full; a
// non-zero byte produces no output, it only updates the entry being built.
// Path: once the terminator is taken, the entry is written into the queue,
// then loaded into the serialiser's register when it is free; it leaves at
// one byte per cycle while entry_out is ready, so one terminator yields
// 11 output bytes.
// Throughput: input is one item per cycle, bounded by the output side only
// through the two-entry entry queue: name_in drops ready while that queue
// is full, i.e. when the receiver stalls long enough for two finished
// entries to pile up behind the one being sent.
// Reset: asynchronous, active low; the entry buffer returns to all spaces,
// counts and phase clear, the queue empties and entry_out goes invalid.
module fat_short_name_converter
    import fsnc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    fsnc_in_if.sink          name_in,
    fsnc_out_if.source       entry_out
);

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t push_entry;
    entry_t head_entry;

    // assemble entry from incoming bytes
    fsnc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (name_in.valid),
        .in_ready   (name_in.ready),
        .in_byte    (name_in.name_byte),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (push_entry)
    );

    // decouples byte intake from the serialiser
    fsnc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_entry (head_entry)
    );

    // serialise entries byte by byte
    fsnc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (entry_out.valid),
        .out_ready  (entry_out.ready),
        .out_byte   (entry_out.out_byte),
        .out_last   (entry_out.out_last)
    );

endmodule
